FILE: src/fmd_pkg.sv
// Shared types, codes and constants of the framed message deframer.
package fmd_pkg;

    // Default width of the message id field in bytes (1 to 4)
    localparam int ID_BYTES_DEFAULT = 4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNATURE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_HEADER    = 3'd0;
    localparam logic [2:0] ST_PAYLOAD   = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    // Parser phase
    typedef enum logic [1:0] {
        PH_SIGNATURE,
        PH_LENGTH,
        PH_ID,
        PH_PAYLOAD
    } phase_t;

    // Configuration register contents
    typedef struct packed {
        logic [31:0] signature_word;
        logic [31:0] max_message_length;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [31:0] message_id;
        logic [31:0] message_length;
        logic        last;
        logic [2:0]  status;
        logic [7:0]  data_byte;
    } result_t;

endpackage

FILE: src/fmd_cfg.sv
// Configuration registers of the framed message deframer.
module fmd_cfg
    import fmd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take writes
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIGNATURE:  cfg_next.signature_word     = cfg_data;
                CFG_MAX_LENGTH: cfg_next.max_message_length = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/fmd_parser.sv
// Header parser: tracks the phase of the current message and forms each result.
module fmd_parser
    import fmd_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    localparam logic [31:0] HEADER_BYTES = 32'(8 + ID_BYTES);

    phase_t      phase_reg,     phase_next;
    logic [31:0] count_reg,     count_next;
    logic [31:0] word_reg,      word_next;
    logic [31:0] length_reg,    length_next;
    logic [31:0] id_reg,        id_next;

    logic [31:0] count_inc;
    logic [31:0] word_merged;
    logic [31:0] id_merged;
    logic        word_done;
    logic        id_done;
    logic        payload_done;
    logic        sig_bad;
    logic        len_short;
    logic        len_long;

    // Merge the byte into the word lane chosen by the low count bits
    always_comb
    begin
        word_merged = word_reg;
        id_merged   = id_reg;
        word_merged[8*count_reg[1:0] +: 8] = rx_byte;
        id_merged[8*count_reg[1:0] +: 8]   = rx_byte;
    end

    // Field boundaries and checks
    assign count_inc    = count_reg + 32'd1;
    assign word_done    = (count_reg[1:0] == 2'd3);
    assign id_done      = (count_inc == HEADER_BYTES);
    assign payload_done = (count_inc >= length_reg);
    assign sig_bad      = (word_merged != cfg.signature_word);
    assign len_short    = (word_merged < HEADER_BYTES);
    assign len_long     = (cfg.max_message_length != 32'd0) &&
                          (word_merged > cfg.max_message_length);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_inc;
        word_next   = word_reg;
        length_next = length_reg;
        id_next     = id_reg;
        unique case (phase_reg)
            PH_SIGNATURE:
            begin
                word_next = word_merged;
                if (word_done)
                begin
                    word_next = '0;
                    if (sig_bad)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH:
            begin
                word_next = word_merged;
                if (word_done)
                begin
                    word_next = '0;
                    if (len_short || len_long)
                    begin
                        phase_next = PH_SIGNATURE;
                        count_next = '0;
                    end
                    else
                    begin
                        length_next = word_merged;
                        phase_next  = PH_ID;
                    end
                end
            end
            PH_ID:
            begin
                id_next = id_merged;
                if (id_done)
                begin
                    if (length_reg <= HEADER_BYTES)
                    begin
                        phase_next  = PH_SIGNATURE;
                        count_next  = '0;
                        length_next = '0;
                        id_next     = '0;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_done)
                begin
                    phase_next  = PH_SIGNATURE;
                    count_next  = '0;
                    length_next = '0;
                    id_next     = '0;
                end
            end
            default:
            begin
                phase_next = PH_SIGNATURE;
            end
        endcase
    end

    // Result fields
    always_comb
    begin
        result                = '0;
        result.data_byte      = rx_byte;
        result.status         = ST_HEADER;
        unique case (phase_reg)
            PH_SIGNATURE:
            begin
                if (word_done && sig_bad)
                begin
                    result.status = ST_BAD_SIG;
                end
            end
            PH_LENGTH:
            begin
                if (word_done)
                begin
                    result.message_length = word_merged;
                    if (len_short)
                    begin
                        result.status = ST_TOO_SHORT;
                    end
                    else if (len_long)
                    begin
                        result.status = ST_TOO_LONG;
                    end
                end
            end
            PH_ID:
            begin
                result.message_length = length_reg;
                if (id_done)
                begin
                    result.message_id = id_merged;
                    result.last       = (length_reg <= HEADER_BYTES);
                end
            end
            PH_PAYLOAD:
            begin
                result.status         = ST_PAYLOAD;
                result.message_length = length_reg;
                result.message_id     = id_reg;
                result.last           = payload_done;
            end
            default:
            begin
                result.status = ST_HEADER;
            end
        endcase
    end

    // Advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIGNATURE;
            count_reg  <= '0;
            word_reg   <= '0;
            length_reg <= '0;
            id_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            word_reg   <= word_next;
            length_reg <= length_next;
            id_reg     <= id_next;
        end
    end

endmodule

FILE: src/fmd_out_stage.sv
// Result register: holds one result word until the downstream side takes it.
module fmd_out_stage
    import fmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    take,
    output logic    full,
    output result_t result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign full       = valid_reg;
    assign result_out = data_reg;

    // Fill on load, drain when taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

FILE: src/framed_message_deframer.sv
// Top level of the framed message deframer.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | tdata: rx_byte
//  m_axis   | m_axis_tvalid/m_axis_tready | tdata, tuser: status, tlast: last
//  cfg      | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
//  One byte per cycle unless m_axis stalls; one result word per byte, registered.
//  The parser state registers feed one level of compare/merge logic into the
//  result register, so a byte is taken whenever that register is empty or
//  being drained in the same cycle.
//  A stall on m_axis holds the result and holds s_axis_tready low.
//  Reset clears the parser to expect a signature, the configuration registers and the result valid flag.
module framed_message_deframer
    import fmd_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // rx_byte [7:0]
    input  logic [7:0]             s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_byte [7:0], message_length [39:8], message_id [71:40]
    output logic [71:0]            m_axis_tdata,
    // status [2:0]
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_t    cfg;
    result_t result_new;
    result_t result_held;
    logic    out_full;
    logic    accept;

    // Take a byte when the result register frees up
    assign s_axis_tready = !out_full || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fmd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fmd_parser #(
        .ID_BYTES (ID_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg),
        .result  (result_new)
    );

    fmd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_new),
        .take       (m_axis_tready),
        .full       (out_full),
        .result_out (result_held)
    );

    // Pack the result word
    assign m_axis_tvalid = out_full;
    assign m_axis_tdata  = {result_held.message_id, result_held.message_length,
                            result_held.data_byte};
    assign m_axis_tuser  = result_held.status;
    assign m_axis_tlast  = result_held.last;

    // End of message only on header or payload words
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == ST_HEADER || m_axis_tuser == ST_PAYLOAD))
        else $error("tlast on an error word");

    // Bad signature carries no length and no id
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_BAD_SIG) |->
            (m_axis_tdata[71:8] == 64'd0))
        else $error("bad signature word with length or id");

    // An empty result register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule
